// ----- design/hbt_pkg.sv -----
// Shared types and constants for the hash bucket table.
package hbt_pkg;

  localparam int MAX_RESULTS = 32;
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);
  localparam int FIELD_W     = 32;
  localparam int FUNC_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int LCNT_W      = 6;
  localparam logic [LCNT_W-1:0] LCNT_MAX = '1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_REMOVE = 2'd2
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_DUP       = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_RD   = 2'd1,
    S_CMP  = 2'd2,
    S_FIN  = 2'd3
  } state_t;

endpackage

// ----- design/hbt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module hbt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/hash_bucket_table_top.sv -----
// Hash bucket of key/value slots with tombstones, scanned from one RAM.
//
// Input channel in_valid/in_ready carries one operation per beat: lookup,
// insert or remove of a key/value pair. Output channel out_valid/out_ready
// returns result beats; insert, remove and unused codes give one beat,
// lookup gives one beat per live matching slot, at most MAX_RESULTS (or one
// not-found beat), with out_last set on the final beat of the item.
// Keys and values live in one RAM read one slot at a time; a scan covers the
// slots written so far, with an address step and a compare step per slot.
// A remove or a duplicate insert ends its scan early on a hit; full-bucket
// inserts and unused codes skip the scan. The next item is taken once the
// previous one has issued its last beat into the output register, so input
// and output overlap by one beat.
// A stalled receiver holds the output register; a lookup with more matches
// waits in place until the register frees.
// Reset empties the bucket at once (live and used tracking are flip-flops);
// the RAM needs no clearing pass.
module hash_bucket_table_top #(
  parameter int SLOTS      = 32,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [hbt_pkg::FUNC_W-1:0]    in_func,
  input  logic [hbt_pkg::FIELD_W-1:0]   in_key,
  input  logic [hbt_pkg::FIELD_W-1:0]   in_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hbt_pkg::FIELD_W-1:0]   out_value_out,
  output logic [hbt_pkg::STATUS_W-1:0]  out_status,
  output logic                          out_last,
  output logic [hbt_pkg::LCNT_W-1:0]    out_live_count
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int ENT_W = KEY_BITS + VALUE_BITS;

  hbt_pkg::state_t state_r, state_nxt;
  hbt_pkg::func_t  func_r, func_nxt;
  logic [KEY_BITS-1:0]       key_r, key_nxt;
  logic [VALUE_BITS-1:0]     val_r, val_nxt;
  logic [IDX_W-1:0]          idx_r, idx_nxt;
  logic [hbt_pkg::RES_W-1:0] n_r, n_nxt;
  logic                      pend_vld_r, pend_vld_nxt;
  logic [VALUE_BITS-1:0]     pend_val_r, pend_val_nxt;
  logic                      full_r, full_nxt;
  logic                      match_r, match_nxt;
  logic                      free_found_r, free_found_nxt;
  logic [IDX_W-1:0]          free_idx_r, free_idx_nxt;
  logic                      bad_func_r, bad_func_nxt;
  logic [SLOTS-1:0]          live_r, live_nxt;
  logic [CNT_W-1:0]          used_len_r, used_len_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [hbt_pkg::FIELD_W-1:0]  out_value_r, out_value_nxt;
  logic [hbt_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic                         out_last_r, out_last_nxt;
  logic [hbt_pkg::LCNT_W-1:0]   out_cnt_r, out_cnt_nxt;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [ENT_W-1:0] ram_wdata;
  logic [ENT_W-1:0] ram_rdata;
  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_val;

  logic             out_free;
  logic             key_hit;
  logic             pair_hit;
  logic             scan_end;
  logic [IDX_W-1:0] ins_slot;

  hbt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  assign rd_key   = ram_rdata[ENT_W-1:VALUE_BITS];
  assign rd_val   = ram_rdata[VALUE_BITS-1:0];
  assign key_hit  = live_r[idx_r] && (rd_key == key_r);
  assign pair_hit = key_hit && (rd_val == val_r);
  assign scan_end = (CNT_W'(idx_r) + CNT_W'(1)) == used_len_r;
  assign out_free = !out_valid_r || out_ready;
  assign ins_slot = free_found_r ? free_idx_r : IDX_W'(used_len_r);

  assign in_ready       = (state_r == hbt_pkg::S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_value_out  = out_value_r;
  assign out_status     = out_status_r;
  assign out_last       = out_last_r;
  assign out_live_count = out_cnt_r;

  function automatic logic [hbt_pkg::LCNT_W-1:0] sat_cnt(input logic [CNT_W-1:0] c);
    logic [7:0] c_ext;
    c_ext = 8'(c);
    return (c_ext > 8'(hbt_pkg::LCNT_MAX)) ? hbt_pkg::LCNT_MAX : c_ext[hbt_pkg::LCNT_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hbt_pkg::S_IDLE;
      live_r      <= '0;
      used_len_r  <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      pend_vld_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      live_r      <= live_nxt;
      used_len_r  <= used_len_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      pend_vld_r  <= pend_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    idx_r        <= idx_nxt;
    n_r          <= n_nxt;
    pend_val_r   <= pend_val_nxt;
    full_r       <= full_nxt;
    match_r      <= match_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    bad_func_r   <= bad_func_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    idx_nxt        = idx_r;
    n_nxt          = n_r;
    pend_vld_nxt   = pend_vld_r;
    pend_val_nxt   = pend_val_r;
    full_nxt       = full_r;
    match_nxt      = match_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    bad_func_nxt   = bad_func_r;
    live_nxt       = live_r;
    used_len_nxt   = used_len_r;
    cnt_nxt        = cnt_r;
    ram_we         = 1'b0;
    ram_waddr      = ins_slot;
    ram_wdata      = {key_r, val_r};

    // drop the held beat once taken
    out_valid_nxt  = out_valid_r && !out_ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    out_cnt_nxt    = out_cnt_r;

    unique case (state_r)
      hbt_pkg::S_IDLE: begin
        if (in_valid) begin
          key_nxt        = KEY_BITS'(in_key);
          val_nxt        = VALUE_BITS'(in_value);
          idx_nxt        = '0;
          n_nxt          = '0;
          pend_vld_nxt   = 1'b0;
          match_nxt      = 1'b0;
          free_found_nxt = 1'b0;
          full_nxt       = (cnt_r == CNT_W'(SLOTS));
          bad_func_nxt   = 1'b0;
          func_nxt       = hbt_pkg::FUNC_LOOKUP;
          state_nxt      = (used_len_r == '0) ? hbt_pkg::S_FIN : hbt_pkg::S_RD;
          unique case (in_func)
            hbt_pkg::FUNC_LOOKUP: func_nxt = hbt_pkg::FUNC_LOOKUP;
            hbt_pkg::FUNC_REMOVE: func_nxt = hbt_pkg::FUNC_REMOVE;
            hbt_pkg::FUNC_INSERT: begin
              func_nxt = hbt_pkg::FUNC_INSERT;
              if (cnt_r == CNT_W'(SLOTS)) begin
                state_nxt = hbt_pkg::S_FIN;
              end
            end
            default: begin
              bad_func_nxt = 1'b1;
              state_nxt    = hbt_pkg::S_FIN;
            end
          endcase
        end
      end

      hbt_pkg::S_RD: begin
        state_nxt = hbt_pkg::S_CMP;
      end

      hbt_pkg::S_CMP: begin
        case (func_r)
          hbt_pkg::FUNC_LOOKUP: begin
            if (key_hit && pend_vld_r && !out_free) begin
              // hold until the output register frees
              state_nxt = hbt_pkg::S_CMP;
            end else begin
              if (key_hit) begin
                if (pend_vld_r) begin
                  out_valid_nxt  = 1'b1;
                  out_value_nxt  = hbt_pkg::FIELD_W'(pend_val_r);
                  out_status_nxt = hbt_pkg::ST_OK;
                  out_last_nxt   = 1'b0;
                  out_cnt_nxt    = sat_cnt(cnt_r);
                end
                pend_vld_nxt = 1'b1;
                pend_val_nxt = rd_val;
                n_nxt        = n_r + hbt_pkg::RES_W'(1);
              end
              if (scan_end ||
                  (key_hit && (n_r + hbt_pkg::RES_W'(1)) ==
                   hbt_pkg::RES_W'(hbt_pkg::MAX_RESULTS))) begin
                state_nxt = hbt_pkg::S_FIN;
              end else begin
                idx_nxt   = idx_r + IDX_W'(1);
                state_nxt = hbt_pkg::S_RD;
              end
            end
          end
          hbt_pkg::FUNC_INSERT: begin
            if (!live_r[idx_r] && !free_found_r) begin
              free_found_nxt = 1'b1;
              free_idx_nxt   = idx_r;
            end
            if (pair_hit) begin
              match_nxt = 1'b1;
              state_nxt = hbt_pkg::S_FIN;
            end else if (scan_end) begin
              state_nxt = hbt_pkg::S_FIN;
            end else begin
              idx_nxt   = idx_r + IDX_W'(1);
              state_nxt = hbt_pkg::S_RD;
            end
          end
          default: begin
            // remove: stop on the first live identical pair, idx_r marks it
            if (pair_hit) begin
              match_nxt = 1'b1;
              state_nxt = hbt_pkg::S_FIN;
            end else if (scan_end) begin
              state_nxt = hbt_pkg::S_FIN;
            end else begin
              idx_nxt   = idx_r + IDX_W'(1);
              state_nxt = hbt_pkg::S_RD;
            end
          end
        endcase
      end

      hbt_pkg::S_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = '0;
          out_last_nxt   = 1'b1;
          out_status_nxt = hbt_pkg::ST_NOT_FOUND;
          out_cnt_nxt    = sat_cnt(cnt_r);
          state_nxt      = hbt_pkg::S_IDLE;
          if (!bad_func_r) begin
            case (func_r)
              hbt_pkg::FUNC_LOOKUP: begin
                if (pend_vld_r) begin
                  out_value_nxt  = hbt_pkg::FIELD_W'(pend_val_r);
                  out_status_nxt = hbt_pkg::ST_OK;
                end
                pend_vld_nxt = 1'b0;
              end
              hbt_pkg::FUNC_INSERT: begin
                if (full_r) begin
                  out_status_nxt = hbt_pkg::ST_FULL;
                end else if (match_r) begin
                  out_status_nxt = hbt_pkg::ST_DUP;
                end else begin
                  ram_we             = 1'b1;
                  live_nxt[ins_slot] = 1'b1;
                  if (!free_found_r) begin
                    used_len_nxt = used_len_r + CNT_W'(1);
                  end
                  cnt_nxt        = cnt_r + CNT_W'(1);
                  out_status_nxt = hbt_pkg::ST_OK;
                  out_cnt_nxt    = sat_cnt(cnt_r + CNT_W'(1));
                end
              end
              default: begin
                if (match_r) begin
                  live_nxt[idx_r] = 1'b0;
                  cnt_nxt         = cnt_r - CNT_W'(1);
                  out_status_nxt  = hbt_pkg::ST_OK;
                  out_cnt_nxt     = sat_cnt(cnt_r - CNT_W'(1));
                end
              end
            endcase
          end
        end
      end

      default: state_nxt = hbt_pkg::S_IDLE;
    endcase
  end

  // Live count tracks the live bits exactly.
  a_cnt_matches_live: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(live_r) == 32'(cnt_r))
    else $error("live count out of step with live bits");

  // Live slots lie inside the used prefix.
  a_live_in_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (live_r >> used_len_r) == '0)
    else $error("live slot beyond used prefix");

  // A compare always addresses a used slot.
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hbt_pkg::S_CMP) |-> (CNT_W'(idx_r) < used_len_r))
    else $error("scan index past used prefix");

  // An accepted item never finds a result beat lost in the register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_value_r)
      && $stable(out_status_r) && $stable(out_last_r)))
    else $error("held result beat overwritten");

endmodule

// ----- test/testbench.sv -----
// Testbench for the hash bucket table: directed, full-bucket, backpressure and random checks.
module testbench;

  localparam int SLOTS       = 32;
  localparam int KEY_BITS    = 32;
  localparam int VALUE_BITS  = 32;
  localparam int CYCLE_LIMIT = 500000;
  localparam int END_CYCLES  = 150;
  localparam int HOLD_CYCLES = 400;
  localparam logic [hbt_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [hbt_pkg::FIELD_W-1:0]  value;
    logic [hbt_pkg::STATUS_W-1:0] status;
    logic                         last;
    logic [hbt_pkg::LCNT_W-1:0]   count;
  } bucket_beat_t;

  logic                         clk            = 1'b0;
  logic                         rst_n          = 1'b0;
  logic                         in_valid       = 1'b0;
  logic [hbt_pkg::FUNC_W-1:0]   in_func        = '0;
  logic [hbt_pkg::FIELD_W-1:0]  in_key         = '0;
  logic [hbt_pkg::FIELD_W-1:0]  in_value       = '0;
  logic                         out_ready      = 1'b0;
  logic                         in_ready;
  logic                         out_valid;
  logic [hbt_pkg::FIELD_W-1:0]  out_value_out;
  logic [hbt_pkg::STATUS_W-1:0] out_status;
  logic                         out_last;
  logic [hbt_pkg::LCNT_W-1:0]   out_live_count;

  always #2 clk = ~clk;

  hash_bucket_table_top #(
    .SLOTS(SLOTS),
    .KEY_BITS(KEY_BITS),
    .VALUE_BITS(VALUE_BITS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_func(in_func),
    .in_key(in_key),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_value_out(out_value_out),
    .out_status(out_status),
    .out_last(out_last),
    .out_live_count(out_live_count)
  );

  // Bucket contents as the testbench expects them.
  logic [hbt_pkg::FIELD_W-1:0] bkt_key [SLOTS];
  logic [hbt_pkg::FIELD_W-1:0] bkt_val [SLOTS];
  logic [SLOTS-1:0]   bkt_used = '0;
  logic [SLOTS-1:0]   bkt_live = '0;
  bucket_beat_t       pending_beats [$];

  int in_gap_max    = 10;
  int out_gap_max   = 10;
  int hold_req      = 0;
  int ops_sent      = 0;
  int beats_checked = 0;
  int errors        = 0;
  int cycle_count   = 0;
  int status_seen [4] = '{0, 0, 0, 0};
  logic [hbt_pkg::FIELD_W-1:0] full_key = '0;

  function automatic logic [hbt_pkg::LCNT_W-1:0] live_slots();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!bkt_used[i]) break;
      if (bkt_live[i]) n++;
    end
    if (n > int'(hbt_pkg::LCNT_MAX)) n = int'(hbt_pkg::LCNT_MAX);
    return n[hbt_pkg::LCNT_W-1:0];
  endfunction

  // Index of the first live slot holding the pair, or SLOTS if none.
  function automatic int find_pair(input logic [hbt_pkg::FIELD_W-1:0] k,
                                   input logic [hbt_pkg::FIELD_W-1:0] v);
    for (int i = 0; i < SLOTS; i++) begin
      if (!bkt_used[i]) break;
      if (bkt_live[i] && bkt_key[i] == k && bkt_val[i] == v) return i;
    end
    return SLOTS;
  endfunction

  function automatic int pick_live_slot();
    int cand [$];
    for (int i = 0; i < SLOTS; i++) begin
      if (bkt_used[i] && bkt_live[i]) cand = {cand, i};
    end
    if (cand.size() == 0) return -1;
    return cand[$urandom_range(cand.size() - 1, 0)];
  endfunction

  function automatic bucket_beat_t make_beat(input logic [hbt_pkg::FIELD_W-1:0] val,
                                             input logic [hbt_pkg::STATUS_W-1:0] st,
                                             input logic fin);
    make_beat = '{value: val, status: st, last: fin, count: live_slots()};
  endfunction

  task automatic queue_beat(input bucket_beat_t beat);
    pending_beats = {pending_beats, beat};
  endtask

  // Apply one operation to the expected bucket and queue the beats it produces.
  task automatic apply_bucket_op(input logic [hbt_pkg::FUNC_W-1:0] func,
                                 input logic [hbt_pkg::FIELD_W-1:0] k,
                                 input logic [hbt_pkg::FIELD_W-1:0] v);
    bucket_beat_t held;
    int hits;
    int slot;
    hits = 0;
    slot = SLOTS;
    case (func)
      hbt_pkg::FUNC_LOOKUP: begin
        // hold back each match until the next one shows whether it is the final beat
        for (int i = 0; i < SLOTS && hits < hbt_pkg::MAX_RESULTS; i++) begin
          if (!bkt_used[i]) break;
          if (bkt_live[i] && bkt_key[i] == k) begin
            if (hits > 0) queue_beat(held);
            held = make_beat(bkt_val[i], hbt_pkg::ST_OK, 1'b0);
            hits++;
          end
        end
        if (hits == 0) begin
          queue_beat(make_beat('0, hbt_pkg::ST_NOT_FOUND, 1'b1));
        end else begin
          held.last = 1'b1;
          queue_beat(held);
        end
      end
      hbt_pkg::FUNC_INSERT: begin
        if (live_slots() >= SLOTS) begin
          queue_beat(make_beat('0, hbt_pkg::ST_FULL, 1'b1));
        end else if (find_pair(k, v) < SLOTS) begin
          queue_beat(make_beat('0, hbt_pkg::ST_DUP, 1'b1));
        end else begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!bkt_live[i]) begin
              slot = i;
              break;
            end
          end
          if (slot < SLOTS) begin
            bkt_key[slot]  = k;
            bkt_val[slot]  = v;
            bkt_live[slot] = 1'b1;
            bkt_used[slot] = 1'b1;
            queue_beat(make_beat('0, hbt_pkg::ST_OK, 1'b1));
          end else begin
            queue_beat(make_beat('0, hbt_pkg::ST_FULL, 1'b1));
          end
        end
      end
      hbt_pkg::FUNC_REMOVE: begin
        slot = find_pair(k, v);
        if (slot < SLOTS) begin
          bkt_live[slot] = 1'b0;
          queue_beat(make_beat('0, hbt_pkg::ST_OK, 1'b1));
        end else begin
          queue_beat(make_beat('0, hbt_pkg::ST_NOT_FOUND, 1'b1));
        end
      end
      default: queue_beat(make_beat('0, hbt_pkg::ST_NOT_FOUND, 1'b1));
    endcase
  endtask

  task automatic send_op(input logic [hbt_pkg::FUNC_W-1:0] func,
                         input logic [hbt_pkg::FIELD_W-1:0] k,
                         input logic [hbt_pkg::FIELD_W-1:0] v);
    int gap;
    gap = $urandom_range(in_gap_max, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func  <= func;
    in_key   <= k;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
    apply_bucket_op(func, k, v);
    ops_sent++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
  endtask

  task automatic compare_field(input string name, input logic [hbt_pkg::FIELD_W-1:0] want,
                               input logic [hbt_pkg::FIELD_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_beat();
    bucket_beat_t want;
    if (pending_beats.size() == 0) begin
      $display("%0t: unexpected beat: expected none, actual value %h status %0d last %0d %s %0d",
               $time, out_value_out, out_status, out_last, "count", out_live_count);
      errors++;
    end else begin
      want = pending_beats.pop_front();
      compare_field("value_out", want.value, out_value_out);
      compare_field("status", hbt_pkg::FIELD_W'(want.status), hbt_pkg::FIELD_W'(out_status));
      compare_field("last", hbt_pkg::FIELD_W'(want.last), hbt_pkg::FIELD_W'(out_last));
      compare_field("live_count", hbt_pkg::FIELD_W'(want.count),
                    hbt_pkg::FIELD_W'(out_live_count));
    end
    beats_checked++;
    status_seen[out_status]++;
  endtask

  // Result side: random stalls, or one long hold-off on request.
  initial begin
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req > 0) begin
        stall = hold_req;
        hold_req = 0;
      end else begin
        stall = $urandom_range(out_gap_max, 0);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      check_beat();
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d beats outstanding", $time, cycle_count,
               pending_beats.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic test_basic_ops();
    send_op(hbt_pkg::FUNC_LOOKUP, 32'h0, 32'h0);
    send_op(hbt_pkg::FUNC_REMOVE, '1, '1);
    send_op(FUNC_UNUSED, '1, '1);
    send_op(hbt_pkg::FUNC_INSERT, 32'h0, 32'h0);
    send_op(hbt_pkg::FUNC_INSERT, '1, '1);
    send_op(hbt_pkg::FUNC_INSERT, '1, '1);
    send_op(hbt_pkg::FUNC_INSERT, '1, 32'h0);
    send_op(hbt_pkg::FUNC_INSERT, 32'h0, '1);
    send_op(hbt_pkg::FUNC_LOOKUP, '1, 32'h0);
    send_op(hbt_pkg::FUNC_LOOKUP, 32'h0, 32'h0);
    // leave a tombstone in slot 0, then miss on it and on a wrong value
    send_op(hbt_pkg::FUNC_REMOVE, 32'h0, 32'h0);
    send_op(hbt_pkg::FUNC_REMOVE, 32'h0, 32'h0);
    send_op(hbt_pkg::FUNC_REMOVE, '1, 32'h1234_5678);
    send_op(hbt_pkg::FUNC_LOOKUP, 32'h0, '1);
    send_op(hbt_pkg::FUNC_INSERT, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    send_op(hbt_pkg::FUNC_LOOKUP, 32'hA5A5_A5A5, 32'h0);
    send_op(hbt_pkg::FUNC_LOOKUP, 32'h5A5A_5A5A, 32'h0);
    send_op(FUNC_UNUSED, 32'h0, 32'h0);
  endtask

  task automatic test_full_bucket();
    int slot;
    slot = pick_live_slot();
    while (slot >= 0) begin
      send_op(hbt_pkg::FUNC_REMOVE, bkt_key[slot], bkt_val[slot]);
      slot = pick_live_slot();
    end
    full_key = $urandom();
    for (int i = 0; i < SLOTS; i++)
      send_op(hbt_pkg::FUNC_INSERT, full_key, ($urandom() << 6) | i);
    send_op(hbt_pkg::FUNC_LOOKUP, full_key, 32'h0);
    send_op(hbt_pkg::FUNC_INSERT, $urandom(), $urandom());
    // a live pair on a full bucket reports full, not duplicate
    send_op(hbt_pkg::FUNC_INSERT, full_key, bkt_val[5]);
    send_op(hbt_pkg::FUNC_REMOVE, full_key, bkt_val[7]);
    send_op(hbt_pkg::FUNC_INSERT, full_key, bkt_val[7]);
    send_op(hbt_pkg::FUNC_LOOKUP, full_key, '1);
  endtask

  task automatic test_backpressure();
    int slot;
    hold_req = HOLD_CYCLES;
    repeat (4) send_op(hbt_pkg::FUNC_LOOKUP, full_key, $urandom());
    send_op(hbt_pkg::FUNC_INSERT, full_key, $urandom());
    // pause input until every beat has drained
    wait_for_results();
    repeat (SLOTS / 2) begin
      slot = pick_live_slot();
      send_op(hbt_pkg::FUNC_REMOVE, bkt_key[slot], bkt_val[slot]);
    end
  endtask

  task automatic test_random();
    logic [hbt_pkg::FIELD_W-1:0] key_pool [6];
    logic [hbt_pkg::FIELD_W-1:0] k;
    logic [hbt_pkg::FIELD_W-1:0] v;
    int choice;
    int slot;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 6; i++) key_pool[i] = $urandom();
    for (int phase = 0; phase < 4; phase++) begin
      // one phase runs back to back on both sides
      in_gap_max  = (phase == 2) ? 0 : 10;
      out_gap_max = (phase == 2) ? 0 : 10;
      repeat (60) begin
        choice = $urandom_range(99, 0);
        k = ($urandom_range(3, 0) == 0) ? $urandom() : key_pool[$urandom_range(5, 0)];
        v = $urandom_range(1, 0) ? $urandom() : $urandom_range(3, 0);
        slot = pick_live_slot();
        if (choice < 40) begin
          if (choice < 6 && slot >= 0) begin
            k = bkt_key[slot];
            v = bkt_val[slot];
          end
          send_op(hbt_pkg::FUNC_INSERT, k, v);
        end else if (choice < 70) begin
          if (choice < 58 && slot >= 0) begin
            k = bkt_key[slot];
            v = bkt_val[slot];
          end else if (choice < 64 && slot >= 0) begin
            k = bkt_key[slot];
          end
          send_op(hbt_pkg::FUNC_REMOVE, k, v);
        end else if (choice < 95) begin
          send_op(hbt_pkg::FUNC_LOOKUP, k, v);
        end else begin
          send_op(FUNC_UNUSED, k, v);
        end
      end
    end
    in_gap_max  = 10;
    out_gap_max = 10;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_basic_ops();
    test_full_bucket();
    test_backpressure();
    test_random();
    wait_for_results();
    repeat (END_CYCLES) @(posedge clk);
    $display("summary: %0d operations sent, %0d result beats checked, incl. a full bucket",
             ops_sent, beats_checked);
    $display("summary: statuses seen ok %0d, not found %0d, full %0d, duplicate %0d",
             status_seen[hbt_pkg::ST_OK], status_seen[hbt_pkg::ST_NOT_FOUND],
             status_seen[hbt_pkg::ST_FULL], status_seen[hbt_pkg::ST_DUP]);
    if (errors == 0 && pending_beats.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
